// ===== src/whitespace_skipping_murmur2_hash_macros.svh =====
// Assertion macros used by the checker file.
`ifndef WHITESPACE_SKIPPING_MURMUR2_HASH_MACROS_SVH
`define WHITESPACE_SKIPPING_MURMUR2_HASH_MACROS_SVH

// Check a property on every clock edge outside reset.
`define WSMH_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define WSMH_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/wsmh_pkg.sv =====
`default_nettype none

package wsmh_pkg;

    // Mixing multiplier and shift amounts
    localparam logic [31:0] MIX_MUL       = 32'd1540483477;
    localparam int unsigned BLOCK_SHIFT   = 24;
    localparam int unsigned FINAL_SHIFT_A = 13;
    localparam int unsigned FINAL_SHIFT_B = 15;

    // Skipped whitespace codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_TAIL,
        ST_FIN_A,
        ST_FIN_B
    } wsmh_state_t;

    // Operand of the shared multiplier
    typedef enum logic [2:0] {
        OP_WORD,
        OP_FOLD,
        OP_HASH,
        OP_TAIL,
        OP_FIN_PROD,
        OP_FIN_HASH
    } wsmh_op_t;

    typedef struct packed {
        logic     accept;
        logic     mul_en;
        wsmh_op_t mul_sel;
        logic     k_load;
        logic     mix_done;
        logic     deliver;
    } wsmh_cmd_t;

    typedef struct packed {
        logic block_full;
        logic tail_nz;
    } wsmh_status_t;

    function automatic logic is_skipped(input logic [7:0] b);
        return (b == CH_TAB) || (b == CH_LF) || (b == CH_CR) || (b == CH_SPACE);
    endfunction

endpackage

`default_nettype wire

// ===== src/wsmh_channels.sv =====
`default_nettype none

// Message byte channel
interface wsmh_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        is_first;
    logic        is_last;
    logic [31:0] kept_count;

    modport source (output valid, data_byte, is_first, is_last, kept_count, input ready);
    modport sink   (input valid, data_byte, is_first, is_last, kept_count, output ready);
endinterface

// Fingerprint channel
interface wsmh_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fingerprint;

    modport source (output valid, fingerprint, input ready);
    modport sink   (input valid, fingerprint, output ready);
endinterface

`default_nettype wire

// ===== src/whitespace_skipping_murmur2_hash.sv =====
`default_nettype none

// Channel  Dir  Fields                                       Accepted when
// msg      in   data_byte, is_first, is_last, kept_count     valid && ready
// res      out  fingerprint                                  valid && ready
//
// A byte that does not complete a 4-byte block is taken without a product; a byte
// that completes one runs three products on the single shared multiplier before
// the next byte is taken. A last byte adds finalisation on the same multiplier,
// and waits further while the output register still holds an untaken result.
// Reset is asynchronous and returns the block to an empty message state.

module whitespace_skipping_murmur2_hash
    import wsmh_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    wsmh_in_if.sink    msg,
    wsmh_out_if.source res
);

    wsmh_cmd_t    cmd;
    wsmh_status_t status;

    wsmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .is_last   (msg.is_last),
        .in_ready  (msg.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    wsmh_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (msg.data_byte),
        .is_first    (msg.is_first),
        .kept_count  (msg.kept_count),
        .cmd         (cmd),
        .status      (status),
        .fingerprint (res.fingerprint)
    );

endmodule

`default_nettype wire

// ===== src/wsmh_ctrl.sv =====
`default_nettype none

module wsmh_ctrl
    import wsmh_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         is_last,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire wsmh_status_t status,
    output wsmh_cmd_t         cmd
);

    wsmh_state_t state_reg, state_next;
    logic        last_reg, last_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign in_ready  = (state_reg == ST_IDLE);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (status.block_full)
                        state_next = ST_MIX1;
                    else if (is_last)
                        state_next = ST_TAIL;
                end
            end
            ST_MIX1:  state_next = ST_MIX2;
            ST_MIX2:  state_next = ST_MIX3;
            ST_MIX3:  state_next = last_reg ? ST_TAIL : ST_IDLE;
            ST_TAIL:  state_next = ST_FIN_A;
            ST_FIN_A: state_next = ST_FIN_B;
            ST_FIN_B:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd = '{accept: 1'b0, mul_en: 1'b0, mul_sel: OP_WORD,
                k_load: 1'b0, mix_done: 1'b0, deliver: 1'b0};
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                cmd.mul_en = in_valid && status.block_full;
            end
            ST_MIX1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = OP_FOLD;
            end
            ST_MIX2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = OP_HASH;
                cmd.k_load  = 1'b1;
            end
            ST_MIX3:  cmd.mix_done = 1'b1;
            ST_TAIL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = OP_TAIL;
            end
            ST_FIN_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = status.tail_nz ? OP_FIN_PROD : OP_FIN_HASH;
            end
            ST_FIN_B: cmd.deliver = slot_free;
            default:  cmd.accept = 1'b0;
        endcase
    end

    // Remember the end mark; hold the result flag until taken
    always_comb
    begin
        last_next = last_reg;
        if (cmd.accept)
            last_next = is_last;
        if (cmd.deliver)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/wsmh_dp.sv =====
`default_nettype none

module wsmh_dp
    import wsmh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_first,
    input  wire logic [31:0] kept_count,
    input  wire wsmh_cmd_t   cmd,
    output wsmh_status_t     status,
    output logic [31:0]      fingerprint
);

    logic [31:0] hash_reg, hash_next;
    logic [23:0] word_reg, word_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] prod_reg;
    logic [31:0] k_reg;
    logic [31:0] fp_reg;

    logic [31:0] eff_hash;
    logic [23:0] eff_word;
    logic [1:0]  eff_cnt;
    logic        kept;
    logic [31:0] operand;

    // A first byte starts from the seeded hash and an empty tail
    assign eff_hash = is_first ? (32'd1 ^ kept_count) : hash_reg;
    assign eff_word = is_first ? 24'd0 : word_reg;
    assign eff_cnt  = is_first ? 2'd0 : cnt_reg;
    assign kept     = !is_skipped(data_byte);

    assign status.block_full = kept && (eff_cnt == 2'd3);
    assign status.tail_nz    = (cnt_reg != 2'd0);
    assign fingerprint       = fp_reg;

    // Select the multiplier operand
    always_comb
    begin
        unique case (cmd.mul_sel)
            OP_WORD:     operand = {data_byte, eff_word};
            OP_FOLD:     operand = prod_reg ^ (prod_reg >> BLOCK_SHIFT);
            OP_HASH:     operand = hash_reg;
            OP_TAIL:     operand = hash_reg ^ {8'd0, word_reg};
            OP_FIN_PROD: operand = prod_reg ^ (prod_reg >> FINAL_SHIFT_A);
            OP_FIN_HASH: operand = hash_reg ^ (hash_reg >> FINAL_SHIFT_A);
            default:     operand = hash_reg;
        endcase
    end

    // Pack kept bytes, fold mixed blocks, clear after a message
    always_comb
    begin
        hash_next = hash_reg;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        if (cmd.accept)
        begin
            hash_next = eff_hash;
            word_next = eff_word;
            cnt_next  = eff_cnt;
            if (kept)
            begin
                if (eff_cnt == 2'd3)
                begin
                    word_next = 24'd0;
                    cnt_next  = 2'd0;
                end
                else
                begin
                    word_next = eff_word | (24'(data_byte) << {eff_cnt, 3'b000});
                    cnt_next  = eff_cnt + 2'd1;
                end
            end
        end
        if (cmd.mix_done)
            hash_next = prod_reg ^ k_reg;
        if (cmd.deliver)
        begin
            hash_next = 32'd0;
            word_next = 24'd0;
            cnt_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= 32'd0;
            word_reg <= 24'd0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            hash_reg <= hash_next;
            word_reg <= word_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Shared multiplier, product registered
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= operand * MIX_MUL;
        if (cmd.k_load)
            k_reg <= prod_reg;
        if (cmd.deliver)
            fp_reg <= prod_reg ^ (prod_reg >> FINAL_SHIFT_B);
    end

endmodule

`default_nettype wire

// ===== src/wsmh_checker.sv =====
`default_nettype none

`include "whitespace_skipping_murmur2_hash_macros.svh"

module wsmh_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        is_last,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] fingerprint
);

    logic [1:0] owed_reg, owed_next;
    logic       last_in;
    logic       res_out;
    logic       res_wait;

    assign last_in  = in_valid && in_ready && is_last;
    assign res_out  = out_valid && out_ready;
    assign res_wait = out_valid && !out_ready;

    // Count messages ended but whose result is not yet taken
    always_comb
    begin
        owed_next = owed_reg;
        if (last_in && !res_out)
            owed_next = owed_reg + 2'd1;
        else if (!last_in && res_out)
            owed_next = owed_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            owed_reg <= 2'd0;
        else
            owed_reg <= owed_next;
    end

    `WSMH_CHECK(a_res_hold, res_wait |=> out_valid && $stable(fingerprint), "result not held")
    `WSMH_CHECK(a_last_busy, last_in |=> !in_ready, "byte taken during finalisation")
    `WSMH_CHECK(a_res_owed, out_valid |-> owed_reg != 2'd0, "result without an ended message")
    `WSMH_CHECK(a_owed_bound, owed_reg != 2'd3, "too many results outstanding")
    `WSMH_CHECK_RST(a_rst_quiet, !rst_n |-> !out_valid, "result shown in reset")

endmodule

bind whitespace_skipping_murmur2_hash wsmh_checker u_wsmh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (msg.valid),
    .in_ready    (msg.ready),
    .is_last     (msg.is_last),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .fingerprint (res.fingerprint)
);

`default_nettype wire

// ===== tb/tb_whitespace_skipping_murmur2_hash.sv =====
`timescale 1ns / 1ps

module tb_whitespace_skipping_murmur2_hash;

    localparam logic [31:0] MURMUR_M     = 32'h5bd1e995;
    localparam int unsigned ITEM_TARGET  = 1450;
    localparam int unsigned QUIET_ITEMS  = 150;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 20;

    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_first;
        logic        is_last;
        logic [31:0] kept_count;
    } msg_word_t;

    class murmur_scoreboard;
        logic [31:0] hash_acc;
        logic [23:0] tail_word;
        logic [1:0]  tail_len;
        logic [31:0] fingerprints_due[$];
        int unsigned errors;

        function new();
            errors = 0;
            restart(32'd0);
        endfunction

        function void restart(logic [31:0] start_hash);
            hash_acc  = start_hash;
            tail_word = '0;
            tail_len  = '0;
        endfunction

        function bit is_blank(logic [7:0] b);
            return b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR || b == BYTE_SPACE;
        endfunction

        function logic [31:0] fold_block(logic [31:0] h, logic [31:0] blk);
            logic [31:0] k;
            k = blk * MURMUR_M;
            k = k ^ (k >> 24);
            k = k * MURMUR_M;
            return (h * MURMUR_M) ^ k;
        endfunction

        // Advance the hash by one accepted word; queue the fingerprint on the last byte
        function void note_byte(msg_word_t w);
            logic [31:0] h;
            if (w.is_first)
                restart(32'd1 ^ w.kept_count);
            if (!is_blank(w.data_byte))
            begin
                if (tail_len == 2'd3)
                begin
                    hash_acc  = fold_block(hash_acc, {w.data_byte, tail_word});
                    tail_word = '0;
                    tail_len  = '0;
                end
                else
                begin
                    tail_word[8*tail_len +: 8] = w.data_byte;
                    tail_len = tail_len + 2'd1;
                end
            end
            if (w.is_last)
            begin
                h = hash_acc;
                if (tail_len != 2'd0)
                    h = (h ^ {8'd0, tail_word}) * MURMUR_M;
                h = (h ^ (h >> 13)) * MURMUR_M;
                h = h ^ (h >> 15);
                fingerprints_due.push_back(h);
                restart(32'd0);
            end
        endfunction

        // Compare a delivered fingerprint with the oldest one due
        function void check_fingerprint(logic [31:0] fp);
            logic [31:0] due;
            if (fingerprints_due.size() == 0)
            begin
                $display("%0t: unexpected fingerprint, expected none, actual %08h", $time, fp);
                errors++;
            end
            else
            begin
                due = fingerprints_due.pop_front();
                if (fp !== due)
                begin
                    $display("%0t: fingerprint mismatch, expected %08h, actual %08h",
                             $time, due, fp);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return fingerprints_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wsmh_in_if  msg_if ();
    wsmh_out_if res_if ();

    whitespace_skipping_murmur2_hash uut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .res   (res_if)
    );

    murmur_scoreboard sb;
    int unsigned items_sent  = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    bit          hold_req    = 1'b0;
    int unsigned idle_cycles = 0;

    always #5 clk = ~clk;

    // Pick an idling rate for the next stretch, none included
    function automatic int unsigned idle_choice();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    // Mostly random bytes, with a good share of whitespace
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 19))
            0: return BYTE_TAB;
            1: return BYTE_LF;
            2: return BYTE_CR;
            3: return BYTE_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one word, after an optional gap, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [31:0] count);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            msg_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        msg_if.valid      <= 1'b1;
        msg_if.data_byte  <= b;
        msg_if.is_first   <= first;
        msg_if.is_last    <= last;
        msg_if.kept_count <= count;
        @(posedge clk);
        while (!msg_if.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Observe both channels at the clock edge
    always @(posedge clk)
    begin
        msg_word_t w;
        if (rst_n)
        begin
            if (msg_if.valid && msg_if.ready)
            begin
                w.data_byte  = msg_if.data_byte;
                w.is_first   = msg_if.is_first;
                w.is_last    = msg_if.is_last;
                w.kept_count = msg_if.kept_count;
                sb.note_byte(w);
            end
            if (res_if.valid && res_if.ready)
                sb.check_fingerprint(res_if.fingerprint);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin
        logic [7:0]  body[$];
        logic [31:0] count;
        int unsigned len;
        int unsigned kept;
        int unsigned kind;
        int unsigned msg_count;
        bit          quiet;
        bit          hold_done;

        sb = new();
        msg_count = 0;
        hold_done = 1'b0;
        rst_n             <= 1'b0;
        msg_if.valid      <= 1'b0;
        msg_if.data_byte  <= 8'd0;
        msg_if.is_first   <= 1'b0;
        msg_if.is_last    <= 1'b0;
        msg_if.kept_count <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 20;
        rx_idle_pct = 20;

        // Bytes with no first mark continue from the reset state
        send_byte(8'h41, 1'b0, 1'b0, 32'd0);
        send_byte(8'hff, 1'b0, 1'b0, 32'd0);
        send_byte(8'h00, 1'b0, 1'b1, 32'd0);
        // Single-byte message, then a lone whitespace byte
        send_byte(8'h7a, 1'b1, 1'b1, 32'd1);
        send_byte(BYTE_SPACE, 1'b1, 1'b1, 32'd0);
        // Exactly one full block, whitespace around it and as the last byte
        send_byte(BYTE_TAB, 1'b1, 1'b0, 32'd4);
        send_byte(8'h61, 1'b0, 1'b0, 32'd4);
        send_byte(8'h62, 1'b0, 1'b0, 32'd4);
        send_byte(BYTE_LF, 1'b0, 1'b0, 32'd4);
        send_byte(8'h63, 1'b0, 1'b0, 32'd4);
        send_byte(8'h64, 1'b0, 1'b0, 32'd4);
        send_byte(BYTE_CR, 1'b0, 1'b0, 32'd4);
        send_byte(BYTE_SPACE, 1'b0, 1'b1, 32'd4);
        // Wrong count at its maximum; one block and a one-byte tail
        send_byte(8'h80, 1'b1, 1'b0, 32'hffff_ffff);
        send_byte(8'h01, 1'b0, 1'b0, 32'hffff_ffff);
        send_byte(8'h7f, 1'b0, 1'b0, 32'hffff_ffff);
        send_byte(8'hfe, 1'b0, 1'b0, 32'hffff_ffff);
        send_byte(8'h55, 1'b0, 1'b1, 32'hffff_ffff);
        // Restart in the middle of a message; two-byte tail
        send_byte(8'h78, 1'b1, 1'b0, 32'd2);
        send_byte(8'h79, 1'b0, 1'b0, 32'd2);
        send_byte(8'h70, 1'b1, 1'b0, 32'd2);
        send_byte(8'h71, 1'b0, 1'b1, 32'd2);

        // Random messages, mostly well formed
        while (items_sent < ITEM_TARGET)
        begin
            quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
            if (quiet)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (msg_count % 40 == 0)
            begin
                tx_idle_pct = idle_choice();
                rx_idle_pct = idle_choice();
            end
            // Hold the result side off once so that the input backs up
            if (!hold_done && items_sent >= 400)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 90 || quiet)
            begin
                if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(13, 48);
                else
                    len = $urandom_range(1, 12);
                body.delete();
                kept = 0;
                for (int i = 0; i < len; i++)
                begin
                    body.push_back(random_byte());
                    if (!sb.is_blank(body[i]))
                        kept++;
                end
                count = (kind < 78 || quiet) ? 32'(kept) : $urandom();
                for (int i = 0; i < len; i++)
                    send_byte(body[i], i == 0, i == len - 1, (i == 0) ? count : $urandom());
            end
            else
            begin
                // Noise: marks fall anywhere
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(random_byte(), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0, $urandom());
            end
            msg_count++;
        end

        // Drain the fingerprints still due
        msg_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
